FILE: rtl/tlc_pkg.sv
// Shared constants, line and row types for the two-level LRU cache hit model.
package tlc_pkg;

    localparam int ADDR_BITS   = 26;
    localparam int BLOCK_BITS  = 6;
    localparam int TAG_BITS    = ADDR_BITS - BLOCK_BITS;
    localparam int STAMP_BITS  = 32;
    localparam int COUNT_BITS  = 32;

    localparam int L1_WAYS     = 4;
    localparam int L1_SETS     = 128;
    localparam int L2_WAYS     = 8;
    localparam int L2_SETS     = 2048;

    localparam int L1_SET_BITS = $clog2(L1_SETS);
    localparam int L2_SET_BITS = $clog2(L2_SETS);
    localparam int L1_WAY_BITS = $clog2(L1_WAYS);
    localparam int L2_WAY_BITS = $clog2(L2_WAYS);

    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [TAG_BITS-1:0]   t_block;
    typedef logic [STAMP_BITS-1:0] t_stamp;
    typedef logic [COUNT_BITS-1:0] t_count;

    // One cache line: valid flag, full block number as tag, LRU timestamp.
    typedef struct packed {
        logic   valid;
        t_block tag;
        t_stamp stamp;
    } t_line;

    typedef t_line [L1_WAYS-1:0] t_l1_row;
    typedef t_line [L2_WAYS-1:0] t_l2_row;

    typedef struct packed {
        logic    hit;
        logic    had_old;
        t_block  old_tag;
        t_l1_row row;
    } t_l1_res;

    typedef struct packed {
        logic    hit;
        t_l2_row row;
    } t_l2_res;

endpackage

FILE: rtl/tlc_req_if.sv
// Request channel carrying one byte address.
interface tlc_req_if;
    import tlc_pkg::*;

    logic  valid;
    logic  ready;
    t_addr byte_address;

    modport source (output valid, output byte_address, input ready);
    modport sink   (input valid, input byte_address, output ready);
endinterface

FILE: rtl/tlc_rsp_if.sv
// Result channel carrying hit flags and running counters.
interface tlc_rsp_if;
    import tlc_pkg::*;

    logic   valid;
    logic   ready;
    logic   l1_hit;
    logic   victim_sent;
    logic   victim_hit_l2;
    logic   l2_hit;
    t_count l1_hits_total;
    t_count l1_misses_total;
    t_count l2_hits_total;
    t_count l2_misses_total;

    modport source (output valid, output l1_hit, output victim_sent, output victim_hit_l2,
                    output l2_hit, output l1_hits_total, output l1_misses_total,
                    output l2_hits_total, output l2_misses_total, input ready);
    modport sink   (input valid, input l1_hit, input victim_sent, input victim_hit_l2,
                    input l2_hit, input l1_hits_total, input l1_misses_total,
                    input l2_hits_total, input l2_misses_total, output ready);
endinterface

FILE: rtl/tlc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/two_level_lru_cache_hit_model_unit.sv
// Top level: two-level tag-only LRU cache model with set rows held in RAMs.
// Steps: accept, then L1 row evaluate, then result on an L1 hit; a miss adds an L2 read
// and L2 evaluate, and when a victim goes to L2 a read and evaluate pass runs for it first.
// Flow: one request at a time; the next is taken once the result has been taken,
// and each request makes read-modify-write passes over the RAMs.
// Reset: a clearing pass over all L2_SETS (2048) rows zeroes both row RAMs; requests wait
// until it ends. Clocks and counters reset to zero.
module two_level_lru_cache_hit_model_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlc_req_if.sink    i_req,
    tlc_rsp_if.source  o_rsp
);
    import tlc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_L1EV  = 6'b000100,
        S_L2RQ  = 6'b001000,
        S_L2EV  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // L1 lookup: hit search, then first invalid way, else oldest stamp (lowest way on ties).
    function automatic t_l1_res l1_access(t_l1_row row, t_block blk, t_stamp clk);
        t_l1_res                res;
        logic                   inv;
        logic [L1_WAY_BITS-1:0] hw;
        logic [L1_WAY_BITS-1:0] pw;
        res.hit = 1'b0;
        hw = '0;
        for (int w = 0; w < L1_WAYS; w++) begin
            if (!res.hit && row[w].valid && row[w].tag == blk) begin
                res.hit = 1'b1;
                hw = L1_WAY_BITS'(w);
            end
        end
        inv = 1'b0;
        pw = '0;
        for (int w = 0; w < L1_WAYS; w++) begin
            if (!row[w].valid) begin
                if (!inv) begin
                    pw = L1_WAY_BITS'(w);
                    inv = 1'b1;
                end
            end else if (!inv && row[w].stamp < row[pw].stamp) begin
                pw = L1_WAY_BITS'(w);
            end
        end
        res.had_old = !res.hit && !inv;
        res.old_tag = row[pw].tag;
        res.row = row;
        if (res.hit) begin
            res.row[hw].stamp = clk;
        end else begin
            res.row[pw] = '{valid: 1'b1, tag: blk, stamp: clk};
        end
        return res;
    endfunction

    // L2 lookup with the same replacement policy.
    function automatic t_l2_res l2_access(t_l2_row row, t_block blk, t_stamp clk);
        t_l2_res                res;
        logic                   inv;
        logic [L2_WAY_BITS-1:0] hw;
        logic [L2_WAY_BITS-1:0] pw;
        res.hit = 1'b0;
        hw = '0;
        for (int w = 0; w < L2_WAYS; w++) begin
            if (!res.hit && row[w].valid && row[w].tag == blk) begin
                res.hit = 1'b1;
                hw = L2_WAY_BITS'(w);
            end
        end
        inv = 1'b0;
        pw = '0;
        for (int w = 0; w < L2_WAYS; w++) begin
            if (!row[w].valid) begin
                if (!inv) begin
                    pw = L2_WAY_BITS'(w);
                    inv = 1'b1;
                end
            end else if (!inv && row[w].stamp < row[pw].stamp) begin
                pw = L2_WAY_BITS'(w);
            end
        end
        res.row = row;
        if (res.hit) begin
            res.row[hw].stamp = clk;
        end else begin
            res.row[pw] = '{valid: 1'b1, tag: blk, stamp: clk};
        end
        return res;
    endfunction

    t_state                 r_state, n_state;
    logic [L2_SET_BITS-1:0] r_clr;
    t_block                 r_block;
    t_block                 r_victim;
    logic                   r_phase;
    t_stamp                 r_l1_clock, r_l2_clock;
    t_count                 r_l1_hits, r_l1_misses, r_l2_hits, r_l2_misses;
    logic                   r_l1_hit, r_vsent, r_vhit, r_l2hit;

    logic                   l1_we, l1_re, l2_we, l2_re;
    logic [L1_SET_BITS-1:0] l1_waddr, l1_raddr;
    logic [L2_SET_BITS-1:0] l2_waddr, l2_raddr;
    t_l1_row                l1_wdata, l1_q;
    t_l2_row                l2_wdata, l2_q;
    t_block                 in_block;
    t_block                 l2_blk;
    t_l1_res                l1_res;
    t_l2_res                l2_res;

    tlc_ram #(.WIDTH($bits(t_l1_row)), .DEPTH(L1_SETS)) u_l1_ram (
        .i_clk   (i_clk),
        .i_we    (l1_we),
        .i_waddr (l1_waddr),
        .i_wdata (l1_wdata),
        .i_re    (l1_re),
        .i_raddr (l1_raddr),
        .o_rdata (l1_q)
    );

    tlc_ram #(.WIDTH($bits(t_l2_row)), .DEPTH(L2_SETS)) u_l2_ram (
        .i_clk   (i_clk),
        .i_we    (l2_we),
        .i_waddr (l2_waddr),
        .i_wdata (l2_wdata),
        .i_re    (l2_re),
        .i_raddr (l2_raddr),
        .o_rdata (l2_q)
    );

    // Block number of the incoming request and the block for the current L2 pass.
    assign in_block = i_req.byte_address[ADDR_BITS-1:BLOCK_BITS];
    assign l2_blk   = r_phase ? r_victim : r_block;
    assign l1_res   = l1_access(l1_q, r_block, r_l1_clock);
    assign l2_res   = l2_access(l2_q, l2_blk, r_l2_clock);

    assign i_req.ready = (r_state == S_IDLE);

    // RAM port control for the clearing pass and each pass of a request.
    always_comb begin
        l1_re    = (r_state == S_IDLE) && i_req.valid;
        l1_raddr = in_block[L1_SET_BITS-1:0];
        l2_re    = (r_state == S_L2RQ);
        l2_raddr = l2_blk[L2_SET_BITS-1:0];
        l1_we    = 1'b0;
        l1_waddr = r_block[L1_SET_BITS-1:0];
        l1_wdata = l1_res.row;
        l2_we    = 1'b0;
        l2_waddr = l2_blk[L2_SET_BITS-1:0];
        l2_wdata = l2_res.row;
        unique case (r_state)
            S_CLEAR: begin
                l1_we    = 1'b1;
                l1_waddr = r_clr[L1_SET_BITS-1:0];
                l1_wdata = '0;
                l2_we    = 1'b1;
                l2_waddr = r_clr;
                l2_wdata = '0;
            end
            S_L1EV: l1_we = 1'b1;
            S_L2EV: l2_we = 1'b1;
            S_IDLE, S_L2RQ, S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == L2_SET_BITS'(L2_SETS - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_req.valid) n_state = S_L1EV;
            S_L1EV:  n_state = l1_res.hit ? S_OUT : S_L2RQ;
            S_L2RQ:  n_state = S_L2EV;
            S_L2EV:  n_state = r_phase ? S_L2RQ : S_OUT;
            S_OUT:   if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers, clocks and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_phase     <= 1'b0;
            r_l1_clock  <= '0;
            r_l2_clock  <= '0;
            r_l1_hits   <= '0;
            r_l1_misses <= '0;
            r_l2_hits   <= '0;
            r_l2_misses <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_L1EV) begin
                r_l1_clock <= r_l1_clock + 1'b1;
                r_phase    <= l1_res.had_old;
                if (l1_res.hit) begin
                    r_l1_hits <= r_l1_hits + 1'b1;
                end else begin
                    r_l1_misses <= r_l1_misses + 1'b1;
                end
            end
            if (r_state == S_L2EV) begin
                r_l2_clock <= r_l2_clock + 1'b1;
                r_phase    <= 1'b0;
                if (l2_res.hit) begin
                    r_l2_hits <= r_l2_hits + 1'b1;
                end else begin
                    r_l2_misses <= r_l2_misses + 1'b1;
                end
            end
        end
    end

    // Request payload and per-request result flags.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_block <= in_block;
        end
        if (r_state == S_L1EV) begin
            r_victim <= l1_res.old_tag;
            r_l1_hit <= l1_res.hit;
            r_vsent  <= l1_res.had_old;
            r_vhit   <= 1'b0;
            r_l2hit  <= 1'b0;
        end
        if (r_state == S_L2EV) begin
            if (r_phase) begin
                r_vhit <= l2_res.hit;
            end else begin
                r_l2hit <= l2_res.hit;
            end
        end
    end

    // Result channel.
    assign o_rsp.valid           = (r_state == S_OUT);
    assign o_rsp.l1_hit          = r_l1_hit;
    assign o_rsp.victim_sent     = r_vsent;
    assign o_rsp.victim_hit_l2   = r_vhit;
    assign o_rsp.l2_hit          = r_l2hit;
    assign o_rsp.l1_hits_total   = r_l1_hits;
    assign o_rsp.l1_misses_total = r_l1_misses;
    assign o_rsp.l2_hits_total   = r_l2_hits;
    assign o_rsp.l2_misses_total = r_l2_misses;
endmodule

FILE: test/two_level_lru_cache_hit_model_unit_tb.sv
// Self-checking bench for the two-level LRU cache hit model: address requests in, hit flags out.
module two_level_lru_cache_hit_model_unit_tb;
    import tlc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 2000;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic   l1_hit;
        logic   victim_sent;
        logic   victim_hit_l2;
        logic   l2_hit;
        t_count l1_hits_total;
        t_count l1_misses_total;
        t_count l2_hits_total;
        t_count l2_misses_total;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    tlc_req_if req_ch ();
    tlc_rsp_if rsp_ch ();

    two_level_lru_cache_hit_model_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Shadow copy of both cache levels.
    logic   l1_v [L1_SETS*L1_WAYS];
    t_block l1_t [L1_SETS*L1_WAYS];
    t_stamp l1_s [L1_SETS*L1_WAYS];
    logic   l2_v [L2_SETS*L2_WAYS];
    t_block l2_t [L2_SETS*L2_WAYS];
    t_stamp l2_s [L2_SETS*L2_WAYS];
    t_stamp l1_now, l2_now;
    t_count l1_hits, l1_misses, l2_hits, l2_misses;

    t_addr    pending_addrs[$];
    t_outcome expected_outcomes[$];
    int       errors = 0;
    int       cycles = 0;
    bit       quiet_tail = 0;
    bit       hold_sender = 0;

    // L2 lookup with install on miss; counts the access.
    function automatic logic l2_lookup(t_block blk);
        int base;
        int pick;
        bit found_free;
        base = int'(blk % L2_SETS) * L2_WAYS;
        pick = 0;
        found_free = 0;
        for (int w = 0; w < L2_WAYS; w++) begin
            if (l2_v[base+w] && l2_t[base+w] == blk) begin
                l2_s[base+w] = l2_now;
                l2_now++;
                l2_hits++;
                return 1'b1;
            end
        end
        for (int w = 0; w < L2_WAYS; w++) begin
            if (!l2_v[base+w]) begin
                if (!found_free) begin
                    pick = w;
                    found_free = 1;
                end
            end else if (!found_free && w > 0 && l2_s[base+w] < l2_s[base+pick]) begin
                pick = w;
            end
        end
        l2_t[base+pick] = blk;
        l2_v[base+pick] = 1'b1;
        l2_s[base+pick] = l2_now;
        l2_now++;
        l2_misses++;
        return 1'b0;
    endfunction

    // Full two-level access for one request.
    function automatic t_outcome cache_access(t_addr addr);
        t_outcome o;
        t_block blk;
        int base;
        int pick;
        bit found_free;
        t_block evicted;
        blk = addr[ADDR_BITS-1:BLOCK_BITS];
        base = int'(blk % L1_SETS) * L1_WAYS;
        pick = 0;
        found_free = 0;
        o = '{default: '0};
        for (int w = 0; w < L1_WAYS; w++) begin
            if (l1_v[base+w] && l1_t[base+w] == blk) begin
                l1_s[base+w] = l1_now;
                l1_now++;
                l1_hits++;
                o.l1_hit = 1'b1;
            end
        end
        if (!o.l1_hit) begin
            for (int w = 0; w < L1_WAYS; w++) begin
                if (!l1_v[base+w]) begin
                    if (!found_free) begin
                        pick = w;
                        found_free = 1;
                    end
                end else if (!found_free && w > 0 && l1_s[base+w] < l1_s[base+pick]) begin
                    pick = w;
                end
            end
            evicted = l1_t[base+pick];
            l1_t[base+pick] = blk;
            l1_v[base+pick] = 1'b1;
            l1_s[base+pick] = l1_now;
            l1_now++;
            l1_misses++;
            if (!found_free) begin
                o.victim_sent = 1'b1;
                o.victim_hit_l2 = l2_lookup(evicted);
            end
            o.l2_hit = l2_lookup(blk);
        end
        o.l1_hits_total = l1_hits;
        o.l1_misses_total = l1_misses;
        o.l2_hits_total = l2_hits;
        o.l2_misses_total = l2_misses;
        return o;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Request driver: random gap bursts unless in the quiet tail.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.byte_address <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid && req_ch.ready) begin
                expected_outcomes.push_back(cache_access(req_ch.byte_address));
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_addrs.size() > 0 && !hold_sender) begin
                req_ch.valid <= 1'b1;
                req_ch.byte_address <= pending_addrs.pop_front();
                if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure bursts.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    t_outcome e;
                    e = expected_outcomes.pop_front();
                    if (rsp_ch.l1_hit !== e.l1_hit) begin
                        $error("l1_hit exp %0d got %0d", e.l1_hit, rsp_ch.l1_hit);
                        errors++;
                    end
                    if (rsp_ch.victim_sent !== e.victim_sent) begin
                        $error("victim_sent exp %0d got %0d", e.victim_sent,
                               rsp_ch.victim_sent);
                        errors++;
                    end
                    if (rsp_ch.victim_hit_l2 !== e.victim_hit_l2) begin
                        $error("victim_hit_l2 exp %0d got %0d", e.victim_hit_l2,
                               rsp_ch.victim_hit_l2);
                        errors++;
                    end
                    if (rsp_ch.l2_hit !== e.l2_hit) begin
                        $error("l2_hit exp %0d got %0d", e.l2_hit, rsp_ch.l2_hit);
                        errors++;
                    end
                    if (rsp_ch.l1_hits_total !== e.l1_hits_total) begin
                        $error("l1_hits_total exp %0d got %0d", e.l1_hits_total,
                               rsp_ch.l1_hits_total);
                        errors++;
                    end
                    if (rsp_ch.l1_misses_total !== e.l1_misses_total) begin
                        $error("l1_misses_total exp %0d got %0d", e.l1_misses_total,
                               rsp_ch.l1_misses_total);
                        errors++;
                    end
                    if (rsp_ch.l2_hits_total !== e.l2_hits_total) begin
                        $error("l2_hits_total exp %0d got %0d", e.l2_hits_total,
                               rsp_ch.l2_hits_total);
                        errors++;
                    end
                    if (rsp_ch.l2_misses_total !== e.l2_misses_total) begin
                        $error("l2_misses_total exp %0d got %0d", e.l2_misses_total,
                               rsp_ch.l2_misses_total);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 18);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL two_level_lru_cache_hit_model_unit");
            $finish;
        end
    end

    // Mostly picks an address whose block falls in one of a few hot L1 sets so
    // that sets fill, evict, and victims land in L2 lines still resident.
    function automatic t_addr pick_address();
        t_block blk;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            // Few tags across few sets: heavy reuse and eviction.
            blk = t_block'($urandom_range(0, 3) + L1_SETS * $urandom_range(0, 11));
            if ($urandom_range(0, 3) == 0) blk = blk + t_block'(L2_SETS * $urandom_range(1, 3));
        end else if (mode < 9) begin
            blk = t_block'($urandom);
        end else begin
            blk = ~t_block'($urandom_range(0, 15) * L1_SETS);
        end
        return {blk, BLOCK_BITS'($urandom)};
    endfunction

    // Stimulus and end of run.
    initial begin
        int last_cycles;
        for (int i = 0; i < L1_SETS*L1_WAYS; i++) begin
            l1_v[i] = 0; l1_t[i] = '0; l1_s[i] = '0;
        end
        for (int i = 0; i < L2_SETS*L2_WAYS; i++) begin
            l2_v[i] = 0; l2_t[i] = '0; l2_s[i] = '0;
        end
        l1_now = '0; l2_now = '0;
        l1_hits = '0; l1_misses = '0; l2_hits = '0; l2_misses = '0;
        req_ch.valid = 1'b0;
        req_ch.byte_address = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: address extremes, a repeat hit, then six blocks in one L1 set
        // so that the set fills and evicts, then revisit evicted blocks (L2 hits).
        pending_addrs.push_back('0);
        pending_addrs.push_back({ADDR_BITS{1'b1}});
        pending_addrs.push_back(t_addr'(6'h3f));
        pending_addrs.push_back({ADDR_BITS{1'b1}} ^ t_addr'(6'h3f));
        for (int k = 1; k <= 6; k++) pending_addrs.push_back(t_addr'(k * L1_SETS) << BLOCK_BITS);
        for (int k = 1; k <= 3; k++) pending_addrs.push_back(t_addr'(k * L1_SETS) << BLOCK_BITS);
        for (int k = 0; k < 10; k++) begin
            pending_addrs.push_back(t_addr'(k * L2_SETS) << BLOCK_BITS | t_addr'(k));
        end
        pending_addrs.push_back(t_addr'(5'h15) << 20 | t_addr'(7));
        pending_addrs.push_back(t_addr'(5'h0a) << 20 | t_addr'(8));

        // Pause the sender until every result is in.
        wait (pending_addrs.size() == 0);
        hold_sender = 1;
        for (int i = 0; i < N_RANDOM; i++) pending_addrs.push_back(pick_address());
        wait (!req_ch.valid && expected_outcomes.size() == 0);
        @(posedge i_clk);
        hold_sender = 0;

        wait (pending_addrs.size() < 300);
        quiet_tail = 1;
        wait (pending_addrs.size() == 0);
        last_cycles = cycles;
        while ((req_ch.valid || expected_outcomes.size() != 0) && cycles - last_cycles < 20000)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_outcomes.size() == 0 && !req_ch.valid) begin
            $display("PASS two_level_lru_cache_hit_model_unit");
        end else begin
            $display("FAIL two_level_lru_cache_hit_model_unit");
        end
        $finish;
    end
endmodule
